### rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and codes of the repeating timer table
// Command and result words, action and result codes, cell chain bus.
// ----------------------------------------------------------------------------
`default_nettype none
package rtt_pkg;

	localparam int TIMER_SLOTS_DEF = 16;

	localparam logic [1:0] ACT_REQUEST = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_CANCEL  = 2'd2;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	localparam logic [1:0] KIND_FIRED   = 2'd0;
	localparam logic [1:0] KIND_STORED  = 2'd1;
	localparam logic [1:0] KIND_DROPPED = 2'd2;
	localparam logic [1:0] KIND_CANCEL  = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [62:0] now_ns;
		logic [31:0] owner_id;
		logic [15:0] timer_id;
		logic [47:0] period_ns;
		logic [15:0] fire_limit;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] owner_id_out;
		logic [15:0] timer_id_out;
		logic        expired;
		logic        last;
	} res_t;

	// OR-combined report of the active cell, passed along the row
	typedef struct packed {
		logic        valid;
		logic        match;
		logic        fire;
		logic        freed;
		logic [31:0] owner;
		logic [15:0] timer;
	} chain_t;

endpackage
`default_nettype wire

### rtl/rtt_cell.sv
// ----------------------------------------------------------------------------
// rtt_cell: one timer slot
// Holds one entry, acts on the command while the scan token sits here.
// ----------------------------------------------------------------------------
`default_nettype none
module rtt_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tok_in,
	output logic                 tok_out,
	input  wire rtt_pkg::cmd_t   cmd,
	input  wire logic            wr,
	input  wire rtt_pkg::chain_t chain_in,
	output rtt_pkg::chain_t      chain_out
);
	logic        tok_q;
	logic        valid_q;
	logic [31:0] owner_q;
	logic [15:0] timer_q;
	logic [63:0] deadline_q;
	logic [47:0] period_q;
	logic [15:0] count_q;
	logic [15:0] limit_q;

	logic        owner_eq;
	logic        due;
	logic [64:0] sum;
	logic [63:0] next_dl;
	logic [15:0] cnt1;
	logic        freed;
	logic        is_tick;
	logic        is_cancel;
	rtt_pkg::chain_t own;

	assign owner_eq  = owner_q == cmd.owner_id;
	assign is_tick   = cmd.action == rtt_pkg::ACT_TICK;
	assign is_cancel = cmd.action == rtt_pkg::ACT_CANCEL;
	assign due       = valid_q && (deadline_q <= {1'b0, cmd.now_ns});
	assign sum       = {1'b0, deadline_q} + {17'd0, period_q};
	assign next_dl   = sum[64] ? {64{1'b1}} : sum[63:0];
	assign cnt1      = count_q + 16'd1;
	assign freed     = cnt1 >= limit_q;
	assign tok_out   = tok_q;

	always_comb begin
		own = '0;
		if (tok_q) begin
			own.valid = valid_q;
			own.match = valid_q && owner_eq && (timer_q == cmd.timer_id);
			own.fire  = is_tick && due;
			own.freed = freed;
			own.owner = owner_q;
			own.timer = timer_q;
		end
		chain_out = chain_in | own;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (wr) begin
				valid_q <= 1'b1;
			end else if (tok_q && is_tick && due && freed) begin
				valid_q <= 1'b0;
			end else if (tok_q && is_cancel && owner_eq) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			owner_q    <= cmd.owner_id;
			timer_q    <= cmd.timer_id;
			deadline_q <= {1'b0, cmd.now_ns} + {16'd0, cmd.period_ns};
			period_q   <= cmd.period_ns;
			count_q    <= '0;
			limit_q    <= cmd.fire_limit;
		end else if (tok_q && is_tick && due) begin
			deadline_q <= next_dl;
			count_q    <= cnt1;
		end
	end
endmodule
`default_nettype wire

### rtl/repeating_timer_table.sv
// ----------------------------------------------------------------------------
// repeating_timer_table: table of repeating timers
// Row of slot cells scanned by a token; requests, ticks and cancels.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy low. A token walks the
// row of TIMER_SLOTS cells, one slot per cycle, then a closing state follows,
// and every request, tick or cancel keeps busy high from the accepting edge
// to the end of the closing state (an unknown action is taken and ignored at once).
// Results appear on result for one cycle each, marked by strobe; the
// receiver cannot stall them. A tick's firings are reported in slot order,
// each one in the cycle after the next firing is found; the last, with last
// set, and the single answer of a request or cancel come in the cycle after
// the closing state, when busy is already low.
`default_nettype none
module repeating_timer_table #(
	parameter int TIMER_SLOTS = rtt_pkg::TIMER_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rtt_pkg::cmd_t cmd,
	output logic               strobe,
	output rtt_pkg::res_t      result
);
	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t          state_q;
	rtt_pkg::cmd_t   cmd_q;
	logic [IW-1:0]   idx_q;
	logic            hit_q, free_q;
	logic [IW-1:0]   hit_idx_q, free_idx_q;
	logic            pend_q;
	logic [31:0]     pend_owner_q;
	logic [15:0]     pend_timer_q;
	logic            pend_freed_q;
	logic            strobe_q;
	rtt_pkg::res_t   result_q;

	logic                 launch;
	logic [TIMER_SLOTS:0] tok;
	rtt_pkg::chain_t      chain [TIMER_SLOTS+1];
	rtt_pkg::chain_t      rep;
	logic                 do_write;
	logic [IW-1:0]        wsel;

	assign launch   = start && !busy && (cmd.action != rtt_pkg::ACT_UNKNOWN);
	assign busy     = state_q != ST_IDLE;
	assign tok[0]   = launch;
	assign chain[0] = '0;
	assign rep      = chain[TIMER_SLOTS];
	assign do_write = (state_q == ST_FINISH) && (cmd_q.action == rtt_pkg::ACT_REQUEST)
		&& (hit_q || free_q);
	assign wsel     = hit_q ? hit_idx_q : free_idx_q;
	assign strobe   = strobe_q;
	assign result   = result_q;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		rtt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.cmd      (cmd_q),
			.wr       (do_write && (wsel == IW'(i))),
			.chain_in (chain[i]),
			.chain_out(chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
			pend_q       <= 1'b0;
			pend_owner_q <= '0;
			pend_timer_q <= '0;
			pend_freed_q <= 1'b0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						pend_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (rep.match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!rep.valid && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (rep.fire) begin
						// release the held firing, hold the new one
						if (pend_q) begin
							strobe_q <= 1'b1;
							result_q <= {rtt_pkg::KIND_FIRED, pend_owner_q, pend_timer_q,
								pend_freed_q, 1'b0};
						end
						pend_q       <= 1'b1;
						pend_owner_q <= rep.owner;
						pend_timer_q <= rep.timer;
						pend_freed_q <= rep.freed;
					end
					if (tok[TIMER_SLOTS]) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					priority if (cmd_q.action == rtt_pkg::ACT_TICK) begin
						if (pend_q) begin
							strobe_q <= 1'b1;
							result_q <= {rtt_pkg::KIND_FIRED, pend_owner_q, pend_timer_q,
								pend_freed_q, 1'b1};
						end
					end else if (cmd_q.action == rtt_pkg::ACT_REQUEST) begin
						strobe_q <= 1'b1;
						result_q <= {(hit_q || free_q) ? rtt_pkg::KIND_STORED
							: rtt_pkg::KIND_DROPPED, cmd_q.owner_id, cmd_q.timer_id,
							1'b0, 1'b1};
					end else begin
						strobe_q <= 1'b1;
						result_q <= {rtt_pkg::KIND_CANCEL, cmd_q.owner_id, 16'd0, 1'b0, 1'b1};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the repeating timer table
// Drives request, tick and cancel words with random gaps, predicts every
// result word from a local copy of the table and checks each strobed word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

	localparam int SLOTS = rtt_pkg::TIMER_SLOTS_DEF;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rtt_pkg::cmd_t cmd = '0;
	logic strobe;
	rtt_pkg::res_t result;

	repeating_timer_table #(.TIMER_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .strobe(strobe), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the table
	bit              tv_valid [SLOTS];
	bit [31:0]       tv_owner [SLOTS];
	bit [15:0]       tv_timer [SLOTS];
	bit [63:0]       tv_deadline [SLOTS];
	bit [47:0]       tv_period [SLOTS];
	bit [15:0]       tv_count [SLOTS];
	bit [15:0]       tv_limit [SLOTS];

	rtt_pkg::res_t   pending_words [$];
	int              error_count = 0;
	longint unsigned cycles = 0;

	// owners and timers kept to a small pool so keys collide
	bit [31:0] owner_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001};
	bit [63:0] clock_now = 0;

	function automatic rtt_pkg::res_t make_word(bit [1:0] k, bit [31:0] o, bit [15:0] t,
		bit e, bit l);
		rtt_pkg::res_t r;
		r.kind = k; r.owner_id_out = o; r.timer_id_out = t;
		r.expired = e; r.last = l;
		return r;
	endfunction

	task automatic predict_table(rtt_pkg::cmd_t c);
		int hit, fresh, n, i;
		bit freed;
		rtt_pkg::res_t fires [$];
		hit = -1; fresh = -1;
		case (c.action)
			rtt_pkg::ACT_REQUEST: begin
				for (i = 0; i < SLOTS; i++) begin
					if (tv_valid[i]) begin
						if (hit < 0 && tv_owner[i] == c.owner_id && tv_timer[i] == c.timer_id)
							hit = i;
					end else if (fresh < 0) fresh = i;
				end
				if (hit < 0) hit = fresh;
				if (hit < 0) begin
					pending_words.push_back(make_word(rtt_pkg::KIND_DROPPED, c.owner_id,
						c.timer_id, 0, 1));
				end else begin
					tv_valid[hit] = 1; tv_owner[hit] = c.owner_id; tv_timer[hit] = c.timer_id;
					tv_deadline[hit] = {1'b0, c.now_ns} + {16'd0, c.period_ns};
					tv_period[hit] = c.period_ns; tv_count[hit] = 0;
					tv_limit[hit] = c.fire_limit;
					pending_words.push_back(make_word(rtt_pkg::KIND_STORED, c.owner_id,
						c.timer_id, 0, 1));
				end
			end
			rtt_pkg::ACT_TICK: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!tv_valid[i] || tv_deadline[i] > {1'b0, c.now_ns}) continue;
					freed = 0;
					if (tv_deadline[i] > 64'hFFFF_FFFF_FFFF_FFFF - {16'd0, tv_period[i]})
						tv_deadline[i] = '1;
					else
						tv_deadline[i] += {16'd0, tv_period[i]};
					tv_count[i] = tv_count[i] + 16'd1;
					if (tv_count[i] >= tv_limit[i]) begin
						tv_valid[i] = 0; freed = 1;
					end
					fires.push_back(make_word(rtt_pkg::KIND_FIRED, tv_owner[i], tv_timer[i],
						freed, 0));
				end
				n = fires.size();
				if (n > 0) fires[n-1].last = 1;
				foreach (fires[j]) pending_words.push_back(fires[j]);
			end
			rtt_pkg::ACT_CANCEL: begin
				for (i = 0; i < SLOTS; i++)
					if (tv_valid[i] && tv_owner[i] == c.owner_id) tv_valid[i] = 0;
				pending_words.push_back(make_word(rtt_pkg::KIND_CANCEL, c.owner_id, 16'd0, 0, 1));
			end
			default: ;
		endcase
	endtask

	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 9) < 4) return;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
		repeat (n) @(posedge clk);
	endtask

	// send one word, hold it until the accepting edge, then drop start
	task automatic send_word(rtt_pkg::cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_table(c);
		start <= 1'b0;
		@(posedge clk);
		idle_gap();
	endtask

	function automatic rtt_pkg::cmd_t build_cmd(bit [1:0] a, bit [62:0] now, bit [31:0] o,
		bit [15:0] t, bit [47:0] p, bit [15:0] l);
		rtt_pkg::cmd_t c;
		c.action = a; c.now_ns = now; c.owner_id = o; c.timer_id = t;
		c.period_ns = p; c.fire_limit = l;
		return c;
	endfunction

	function automatic bit [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word kind %0d", result.kind);
				error_count++;
			end else begin
				rtt_pkg::res_t w;
				w = pending_words.pop_front();
				if (result.kind !== w.kind) begin
					$error("kind exp %0d got %0d", w.kind, result.kind); error_count++;
				end
				if (result.owner_id_out !== w.owner_id_out) begin
					$error("owner_id_out exp %h got %h", w.owner_id_out, result.owner_id_out);
					error_count++;
				end
				if (result.timer_id_out !== w.timer_id_out) begin
					$error("timer_id_out exp %h got %h", w.timer_id_out, result.timer_id_out);
					error_count++;
				end
				if (result.expired !== w.expired) begin
					$error("expired exp %b got %b", w.expired, result.expired); error_count++;
				end
				if (result.last !== w.last) begin
					$error("last exp %b got %b", w.last, result.last); error_count++;
				end
			end
		end
	end

	task automatic test_directed();
		int i;
		bit [62:0] big;
		big = '1;
		send_word(build_cmd(rtt_pkg::ACT_TICK, 0, 0, 0, 0, 0));  // nothing due
		send_word(build_cmd(rtt_pkg::ACT_CANCEL, 0, 32'hDEAD_BEEF, 0, 0, 0)); // empty cancel
		send_word(build_cmd(rtt_pkg::ACT_REQUEST, 0, 0, 0, 0, 0)); // limit zero, period zero
		send_word(build_cmd(rtt_pkg::ACT_REQUEST, 10, 32'hFFFF_FFFF, 16'hFFFF,
			48'hFFFF_FFFF_FFFF, 16'hFFFF));
		send_word(build_cmd(rtt_pkg::ACT_REQUEST, big, 1, 1, 48'hFFFF_FFFF_FFFF, 3)); // overflow
		send_word(build_cmd(rtt_pkg::ACT_REQUEST, 5, 0, 0, 3, 2)); // overwrite key
		send_word(build_cmd(rtt_pkg::ACT_UNKNOWN, big, '1, '1, '1, '1)); // unknown action
		send_word(build_cmd(rtt_pkg::ACT_TICK, big, 0, 0, 0, 0));
		send_word(build_cmd(rtt_pkg::ACT_TICK, big, 0, 0, 0, 0));
		send_word(build_cmd(rtt_pkg::ACT_TICK, big, 0, 0, 0, 0));
		for (i = 0; i < 17; i++) // fill and overflow the table
			send_word(build_cmd(rtt_pkg::ACT_REQUEST, 0, 32'h55, i[15:0], 1, 16'hFFFF));
		send_word(build_cmd(rtt_pkg::ACT_TICK, 1, 0, 0, 0, 0));
		send_word(build_cmd(rtt_pkg::ACT_CANCEL, 0, 32'h55, 0, 0, 0));
		send_word(build_cmd(rtt_pkg::ACT_CANCEL, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_word(build_cmd(rtt_pkg::ACT_CANCEL, 0, 1, 0, 0, 0));
	endtask

	task automatic test_random();
		int i, r;
		rtt_pkg::cmd_t c;
		for (i = 0; i < 350; i++) begin
			r = $urandom_range(0, 99);
			c = build_cmd(rtt_pkg::ACT_REQUEST, rand63(), owner_pool[$urandom_range(0, 3)],
				16'($urandom_range(0, 5)), 48'({$urandom(), $urandom()}),
				16'($urandom_range(0, 6)));
			if ($urandom_range(0, 9) == 0) begin
				c.owner_id = $urandom(); c.timer_id = 16'($urandom());
				c.fire_limit = 16'($urandom());
			end
			if (r < 40) begin
				// short periods near the running clock so entries fire
				c.now_ns = clock_now[62:0];
				if ($urandom_range(0, 4) != 0) c.period_ns = 48'($urandom_range(0, 50));
			end else if (r < 85) begin
				c.action = rtt_pkg::ACT_TICK;
				clock_now += 64'($urandom_range(0, 40));
				c.now_ns = ($urandom_range(0, 29) == 0) ? rand63() : clock_now[62:0];
			end else if (r < 97) begin
				c.action = rtt_pkg::ACT_CANCEL;
			end else begin
				c.action = rtt_pkg::ACT_UNKNOWN;
			end
			send_word(c);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		while (pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### repeating_timer_table.f
rtl/rtt_pkg.sv
rtl/rtt_cell.sv
rtl/repeating_timer_table.sv
dv/testbench.sv
